// ===== sv/mlwta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlwta_pkg
// Shared types and constants of the lag-weighted time average block.
// ----------------------------------------------------------------------------
package mlwta_pkg;

  localparam int IDX_W    = 12;
  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 17;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = 33;
  localparam int SUM_W    = 38;
  localparam int TOT_W    = 22;
  localparam int ENTRY_W  = SUM_W + TOT_W;
  localparam int QUO_W    = 16;

  // 3600 = 16 * 225: shift by four, then multiply by a reciprocal of 225
  localparam int LAG_PRE_SHIFT = 4;
  localparam int RECIP_W       = 29;
  localparam int RECIP_SHIFT   = 36;
  localparam logic [RECIP_W-1:0] RECIP_225 = 29'd305419897;
  localparam int MAG_W         = 28;
  localparam int DELTA_W       = 21;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CFG_CURRENT_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_WEIGHT_SLOPE   = 2'd1;
  localparam logic [1:0] CFG_MISSING_CODE   = 2'd2;
  localparam logic [1:0] CFG_BAD_CODE       = 2'd3;

  typedef enum logic [1:0] {
    ITEM_ACC,
    ITEM_FIN,
    ITEM_FIN_OOR
  } item_kind_e;

  typedef struct packed {
    logic        [WEIGHT_W-1:0] current_weight;
    logic signed [15:0]         weight_slope;
    logic signed [SAMPLE_W-1:0] missing_code;
    logic signed [SAMPLE_W-1:0] bad_code;
  } cfg_t;

  typedef struct packed {
    item_kind_e                 kind;
    logic        [IDX_W-1:0]    idx;
    logic signed [PROD_W-1:0]   prod;
    logic        [WEIGHT_W-1:0] weight;
  } queue_item_t;

endpackage
`default_nettype wire

// ===== sv/mlwta_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlwta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlwta_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 4096
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/mlwta_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlwta_front
// Accepts items, drops skipped samples, computes frame weight and product.
// ----------------------------------------------------------------------------
module mlwta_front
  import mlwta_pkg::*;
#(
  parameter int POINTS = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       in_mode_i,
  input  wire logic        [IDX_W-1:0]    in_index_i,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_i,
  input  wire logic        [LAG_W-1:0]    in_lag_i,
  input  wire cfg_t                       cfg_i,
  input  wire logic                       clearing_i,
  output logic                            q_valid_o,
  input  wire logic                       q_ready_i,
  output queue_item_t                     q_item_o
);

  typedef struct packed {
    item_kind_e                 kind;
    logic        [IDX_W-1:0]    idx;
    logic signed [SAMPLE_W-1:0] sample;
  } meta_t;

  logic [4:0] vld_q;
  logic       adv;
  logic       accept;
  logic       in_range;
  logic       keep;
  meta_t      meta_in;
  meta_t      m1_q, m2_q, m3_q, m4_q, m5_q;

  logic signed [LAG_W+16:0]      p1_q;
  logic        [LAG_W+16:0]      p1_abs;
  logic        [MAG_W-1:0]       mag2_q;
  logic                          neg2_q;
  logic        [MAG_W+RECIP_W-1:0] qprod;
  logic        [DELTA_W-1:0]     q3_q;
  logic                          neg3_q;
  logic signed [22:0]            wsum;
  logic        [WEIGHT_W-1:0]    wclamp;
  logic        [WEIGHT_W-1:0]    w4_q;
  logic        [WEIGHT_W-1:0]    w5_q;
  logic signed [PROD_W-1:0]      prod5_q;

  assign adv        = !vld_q[4] || q_ready_i;
  assign in_ready_o = adv && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = 32'(in_index_i) < 32'(POINTS);

  always_comb begin
    meta_in.idx    = in_index_i;
    meta_in.sample = in_sample_i;
    if (in_mode_i) begin
      meta_in.kind = in_range ? ITEM_FIN : ITEM_FIN_OOR;
      keep         = 1'b1;
    end else begin
      meta_in.kind = ITEM_ACC;
      keep         = in_range && (in_sample_i != cfg_i.missing_code)
                     && (in_sample_i != cfg_i.bad_code);
    end
  end

  assign p1_abs = p1_q[LAG_W+16] ? (LAG_W+17)'(-p1_q) : p1_q;
  assign qprod  = (MAG_W+RECIP_W)'(mag2_q) * (MAG_W+RECIP_W)'(RECIP_225);
  assign wsum   = neg3_q ? $signed({7'b0, cfg_i.current_weight}) - $signed({2'b0, q3_q})
                         : $signed({7'b0, cfg_i.current_weight}) + $signed({2'b0, q3_q});

  always_comb begin
    if (wsum[22]) begin
      wclamp = '0;
    end else if (|wsum[21:16]) begin
      wclamp = '1;
    end else begin
      wclamp = wsum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], accept && keep};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= meta_in;
      p1_q    <= $signed({1'b0, in_lag_i}) * cfg_i.weight_slope;
      m2_q    <= m1_q;
      neg2_q  <= p1_q[LAG_W+16];
      mag2_q  <= p1_abs[MAG_W+LAG_PRE_SHIFT-1:LAG_PRE_SHIFT];
      m3_q    <= m2_q;
      neg3_q  <= neg2_q;
      q3_q    <= qprod[RECIP_SHIFT+DELTA_W-1:RECIP_SHIFT];
      m4_q    <= m3_q;
      w4_q    <= wclamp;
      m5_q    <= m4_q;
      w5_q    <= w4_q;
      prod5_q <= m4_q.sample * $signed({1'b0, w4_q});
    end
  end

  assign q_valid_o       = vld_q[4];
  assign q_item_o.kind   = m5_q.kind;
  assign q_item_o.idx    = m5_q.idx;
  assign q_item_o.prod   = prod5_q;
  assign q_item_o.weight = w5_q;

endmodule
`default_nettype wire

// ===== sv/mlwta_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlwta_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module mlwta_queue
  import mlwta_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire queue_item_t push_item_i,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i,
  output queue_item_t      pop_item_o
);

  queue_item_t       entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mlwta_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlwta_back
// Per-point accumulator store, read-modify-write, divider and result register.
// ----------------------------------------------------------------------------
module mlwta_back
  import mlwta_pkg::*;
#(
  parameter int POINTS = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfg_t                       cfg_i,
  output logic                            clearing_o,
  input  wire logic                       head_valid_i,
  output logic                            pop_o,
  input  wire queue_item_t                head_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic        [IDX_W-1:0]         out_index_o,
  output logic signed [SAMPLE_W-1:0]      out_smoothed_o,
  output logic                            out_missing_o
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_cnt_q;
  queue_item_t       cur_q;
  logic              miss_q;
  logic              neg_q;
  logic [TOT_W-1:0]  div_q;
  logic [TOT_W-1:0]  rem_q;
  logic [QUO_W-1:0]  num_q;
  logic [QUO_W-1:0]  quo_q;
  logic [3:0]        cnt_q;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [ENTRY_W-1:0]      wdata;
  logic [ENTRY_W-1:0]      rdata;
  logic signed [SUM_W-1:0] old_sum;
  logic [TOT_W-1:0]        old_tot;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] new_sum;
  logic [TOT_W:0]          tot_ext;
  logic [TOT_W-1:0]        new_tot;
  logic [SUM_W-1:0]        sum_abs;
  logic [TOT_W:0]          rem_sh;
  logic                    rem_ge;
  logic signed [SAMPLE_W-1:0] quo_res;
  logic                    out_free;

  assign old_sum = rdata[ENTRY_W-1:TOT_W];
  assign old_tot = rdata[TOT_W-1:0];
  assign sum_ext = $signed({old_sum[SUM_W-1], old_sum})
                 + $signed({{(SUM_W+1-PROD_W){cur_q.prod[PROD_W-1]}}, cur_q.prod});
  assign tot_ext = {1'b0, old_tot} + (TOT_W+1)'(cur_q.weight);

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      new_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      new_sum = sum_ext[SUM_W-1:0];
    end
    new_tot = tot_ext[TOT_W] ? '1 : tot_ext[TOT_W-1:0];
  end

  assign sum_abs = old_sum[SUM_W-1] ? SUM_W'(-old_sum) : old_sum;
  assign rem_sh  = {rem_q, num_q[QUO_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_q};

  always_comb begin
    if (neg_q) begin
      quo_res = (quo_q > 16'd32768) ? 16'sh8000 : $signed(16'(~quo_q + 16'd1));
    end else begin
      quo_res = (quo_q > 16'd32767) ? 16'sh7FFF : $signed(quo_q);
    end
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign clearing_o = state_q == ST_CLEAR;
  assign pop_o      = (state_q == ST_IDLE) && head_valid_i;
  assign we         = (state_q == ST_CLEAR) || (state_q == ST_RMW);
  assign waddr      = (state_q == ST_CLEAR) ? clr_cnt_q : AW'(cur_q.idx);
  assign wdata      = ((state_q == ST_RMW) && (cur_q.kind == ITEM_ACC))
                      ? {new_sum, new_tot} : '0;

  mlwta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (AW'(head_i.idx)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      cur_q          <= '0;
      miss_q         <= 1'b0;
      neg_q          <= 1'b0;
      div_q          <= '0;
      rem_q          <= '0;
      num_q          <= '0;
      quo_q          <= '0;
      cnt_q          <= '0;
      out_valid_o    <= 1'b0;
      out_index_o    <= '0;
      out_smoothed_o <= '0;
      out_missing_o  <= 1'b0;
    end else begin
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(POINTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head_valid_i) begin
            cur_q <= head_i;
            if (head_i.kind == ITEM_FIN_OOR) begin
              miss_q  <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_RMW;
            end
          end
        end
        ST_RMW: begin
          if (cur_q.kind == ITEM_ACC) begin
            state_q <= ST_IDLE;
          end else if ((old_tot == '0) || (old_tot < TOT_W'(cfg_i.current_weight))) begin
            miss_q  <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            miss_q <= 1'b0;
            neg_q  <= old_sum[SUM_W-1];
            if (sum_abs >= {old_tot, {QUO_W{1'b0}}}) begin
              quo_q   <= '1;
              state_q <= ST_EMIT;
            end else begin
              rem_q   <= sum_abs[SUM_W-1:QUO_W];
              num_q   <= sum_abs[QUO_W-1:0];
              div_q   <= old_tot;
              cnt_q   <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= rem_ge ? TOT_W'(rem_sh - {1'b0, div_q}) : rem_sh[TOT_W-1:0];
          quo_q <= {quo_q[QUO_W-2:0], rem_ge};
          num_q <= {num_q[QUO_W-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(QUO_W - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_o    <= 1'b1;
            out_index_o    <= cur_q.idx;
            out_smoothed_o <= miss_q ? cfg_i.missing_code : quo_res;
            out_missing_o  <= miss_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  a_acc_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW && cur_q.kind == ITEM_ACC) |=> state_q == ST_IDLE)
    else $error("accumulate did not finish after write back");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> out_valid_o)
    else $error("result not loaded into output register");

  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_RMW || state_q == ST_EMIT))
    else $error("popped item not taken up");

endmodule
`default_nettype wire

// ===== sv/masked_lag_weighted_time_average.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_lag_weighted_time_average
// Per-point lag-weighted temporal average with masked samples.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata index,sample,lag; tuser mode
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata index,smoothed; tuser missing
//  cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
//  front: 5 stage weight pipeline, one item per cycle into a 4 entry queue while the queue takes them
//  accumulate: in the back, a read, then a write of one store entry
//  finish: store read, then a bit-serial divide for the 16 bit quotient (skipped if it saturates or
//  the point is missing), then the result load; out of range finish: straight to the result load;
//  skipped samples cost nothing in the back; after reset a clearing pass runs with s_axis_tready low
// ----------------------------------------------------------------------------
module masked_lag_weighted_time_average
  import mlwta_pkg::*;
#(
  parameter int POINTS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // point_index, sample, lag_seconds
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_index, smoothed
  output logic             m_axis_tuser,  // was_missing
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t        cfg_q;
  logic        clearing;
  logic        q_in_valid, q_in_ready;
  queue_item_t q_in_item;
  logic        head_valid, pop;
  queue_item_t head;
  logic [IDX_W-1:0]           out_index;
  logic signed [SAMPLE_W-1:0] out_smoothed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_weight <= 16'd256;
      cfg_q.weight_slope   <= 16'sd0;
      cfg_q.missing_code   <= 16'sh8000;
      cfg_q.bad_code       <= 16'sh8001;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CURRENT_WEIGHT: cfg_q.current_weight <= cfg_data_i;
        CFG_WEIGHT_SLOPE:   cfg_q.weight_slope   <= $signed(cfg_data_i);
        CFG_MISSING_CODE:   cfg_q.missing_code   <= $signed(cfg_data_i);
        CFG_BAD_CODE:       cfg_q.bad_code       <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  mlwta_front #(
    .POINTS (POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_index_i  (s_axis_tdata[11:0]),
    .in_sample_i ($signed(s_axis_tdata[27:12])),
    .in_lag_i    (s_axis_tdata[44:28]),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .q_valid_o   (q_in_valid),
    .q_ready_i   (q_in_ready),
    .q_item_o    (q_in_item)
  );

  mlwta_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_item_i  (q_in_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (pop),
    .pop_item_o   (head)
  );

  mlwta_back #(
    .POINTS (POINTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .clearing_o     (clearing),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .head_i         (head),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_index_o    (out_index),
    .out_smoothed_o (out_smoothed),
    .out_missing_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, out_smoothed, out_index};

endmodule
`default_nettype wire

// ===== verif/masked_lag_weighted_time_average_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_lag_weighted_time_average_test
// Self-checking bench for the lag-weighted time average. Frames of samples
// are streamed into a set of grid points under several register settings,
// and every emitted mean is compared with a mean tracked on the bench side.
// ----------------------------------------------------------------------------
module masked_lag_weighted_time_average_test;
  import mlwta_pkg::*;

  localparam int GRID_POINTS    = 4096;
  localparam int SECONDS_PER_HR = 3600;
  localparam int SETTLE_CYCLES  = 64;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PH   = 125;
  localparam bit MODE_ACCUMULATE = 1'b0;
  localparam bit MODE_FINISH     = 1'b1;
  localparam longint SUM_HI = 64'sd137438953471;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned TOT_HI = 32'd4194303;

  typedef struct {
    bit [IDX_W-1:0] idx;
    shortint        mean;
    bit             missing;
  } point_mean_t;

  class weighted_mean_tracker;
    bit [WEIGHT_W-1:0] cur_weight = 16'd256;
    shortint           slope      = 16'sd0;
    shortint           miss_code  = -16'sd32768;
    shortint           bad_code   = -16'sd32767;
    longint            sums[GRID_POINTS];
    int unsigned       totals[GRID_POINTS];
    point_mean_t       pending_means[$];
    int                errors;

    function void set_reg(logic [1:0] index, bit [15:0] value);
      case (index)
        CFG_CURRENT_WEIGHT: cur_weight = value;
        CFG_WEIGHT_SLOPE:   slope = value;
        CFG_MISSING_CODE:   miss_code = value;
        CFG_BAD_CODE:       bad_code = value;
        default: ;
      endcase
    endfunction

    function int unsigned frame_weight(bit [LAG_W-1:0] lag);
      longint delta;
      longint w;
      delta = (longint'(lag) * longint'(slope)) / SECONDS_PER_HR;
      w = longint'(cur_weight) + delta;
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      return int'(w);
    endfunction

    function void note_item(bit mode, bit [IDX_W-1:0] idx, shortint sample,
                            bit [LAG_W-1:0] lag);
      int unsigned w;
      longint      s;
      longint      q;
      longint      t;
      point_mean_t r;
      if (mode == MODE_ACCUMULATE) begin
        if (idx >= GRID_POINTS || sample == miss_code || sample == bad_code) return;
        w = frame_weight(lag);
        s = sums[idx] + longint'(sample) * longint'(w);
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        sums[idx] = s;
        t = longint'(totals[idx]) + longint'(w);
        totals[idx] = (t > TOT_HI) ? TOT_HI : int'(t);
        return;
      end
      r.idx = idx;
      r.mean = miss_code;
      r.missing = 1'b1;
      if (idx < GRID_POINTS) begin
        if (totals[idx] != 0 && totals[idx] >= cur_weight) begin
          q = sums[idx] / longint'(totals[idx]);
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          r.mean = shortint'(q);
          r.missing = 1'b0;
        end
        sums[idx] = 0;
        totals[idx] = 0;
      end
      pending_means.push_back(r);
    endfunction

    function void check_mean(bit [IDX_W-1:0] idx, shortint mean, bit missing);
      point_mean_t e;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: point %0d mean %0d missing %0b", idx, mean, missing);
        return;
      end
      e = pending_means.pop_front();
      if (e.idx != idx || e.mean != mean || e.missing != missing) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected point %0d mean %0d missing %0b, got point %0d mean %0d missing %0b",
                   e.idx, e.mean, e.missing, idx, mean, missing);
      end
    endfunction

    function int pending_size();
      return pending_means.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  weighted_mean_tracker tracker = new();
  bit             quiet_phase = 1'b0;
  int             sent_items;
  int             stall_left;
  int             cycle_count;
  bit [IDX_W-1:0] point_pool[16];

  masked_lag_weighted_time_average #(.POINTS(GRID_POINTS)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_phase && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_mean(m_axis_tdata[11:0], shortint'(m_axis_tdata[27:12]), m_axis_tuser);
  end

  task automatic push_item(bit mode, bit [IDX_W-1:0] pt, shortint smp, bit [LAG_W-1:0] lag);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {3'b000, lag, smp, pt};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(mode, pt, smp, lag);
    sent_items++;
  endtask

  task automatic write_reg(logic [1:0] index, bit [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(index, value);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure_phase(int ph);
    bit [15:0] cw;
    bit [15:0] sl;
    bit [15:0] mc;
    bit [15:0] bc;
    cw = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 512)) : 16'($urandom());
    sl = 16'($urandom());
    mc = 16'($urandom());
    bc = 16'($urandom());
    case (ph)
      1: begin cw = 16'd0;     sl = 16'h7fff; end
      2: begin cw = 16'hffff;  sl = 16'h7fff; mc = 16'h8000; bc = 16'h8001; end
      3: begin cw = 16'hffff;  sl = 16'h8000; mc = 16'h7fff; bc = 16'h0000; end
      4: begin cw = 16'd256;   sl = 16'h8000; mc = 16'h0000; bc = 16'h0000; end
      default: ;
    endcase
    write_reg(CFG_CURRENT_WEIGHT, cw);
    write_reg(CFG_WEIGHT_SLOPE, sl);
    write_reg(CFG_MISSING_CODE, mc);
    write_reg(CFG_BAD_CODE, bc);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic shortint pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return tracker.miss_code;
    if (r < 15) return tracker.bad_code;
    if (r < 20) return 16'sd32767;
    if (r < 25) return -16'sd32768;
    if (r < 50) return shortint'($urandom_range(0, 200)) - 16'sd100;
    return shortint'($urandom());
  endfunction

  function automatic bit [LAG_W-1:0] pick_lag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 45) return LAG_W'(SECONDS_PER_HR * $urandom_range(0, 24));
    if (r < 90) return LAG_W'($urandom_range(0, 86400));
    return LAG_W'($urandom_range(0, 131071));
  endfunction

  // frames for one point, mostly closed by a finish
  task automatic run_series(bit heavy);
    bit [IDX_W-1:0] pt;
    int             frames;
    bit             high_side;
    shortint        smp;
    pt = $urandom_range(0, 9) < 7 ? point_pool[$urandom_range(0, 15)] : IDX_W'($urandom());
    high_side = $urandom_range(0, 1);
    if (heavy) frames = $urandom_range(66, 72);
    else if ($urandom_range(0, 9) == 0) frames = $urandom_range(9, 64);
    else frames = $urandom_range(1, 8);
    for (int i = 0; i < frames; i++) begin
      smp = heavy ? (high_side ? 16'sd32767 : -16'sd32768) : pick_sample();
      push_item(MODE_ACCUMULATE, pt, smp,
                heavy ? LAG_W'($urandom_range(0, 3600)) : pick_lag());
    end
    if (heavy || $urandom_range(0, 9) != 0)
      push_item(MODE_FINISH, pt, shortint'($urandom()), LAG_W'($urandom()));
  endtask

  initial begin
    point_pool[0] = '0;
    point_pool[1] = '1;
    for (int i = 2; i < 16; i++) point_pool[i] = IDX_W'($urandom());
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: weight 1.0, flat slope
    push_item(MODE_ACCUMULATE, 12'd0, 16'sd32767, 17'd0);
    push_item(MODE_ACCUMULATE, 12'd0, 16'sd1, 17'h1ffff);
    push_item(MODE_FINISH, 12'd0, 16'sd0, 17'd0);
    push_item(MODE_ACCUMULATE, 12'd1, -16'sd32768, 17'd0);
    push_item(MODE_ACCUMULATE, 12'd1, -16'sd32767, 17'd0);
    push_item(MODE_FINISH, 12'd1, -16'sd1, 17'h1ffff);
    push_item(MODE_ACCUMULATE, 12'hfff, -16'sd7, 17'd86400);
    push_item(MODE_ACCUMULATE, 12'hfff, 16'sd4, 17'd3600);
    push_item(MODE_FINISH, 12'hfff, 16'sd0, 17'd0);
    push_item(MODE_FINISH, 12'd2, 16'sd0, 17'd0);
    push_item(MODE_ACCUMULATE, 12'd3, -16'sd32766, 17'd0);
    push_item(MODE_FINISH, 12'd3, 16'sd0, 17'd0);
    push_item(MODE_FINISH, 12'd3, 16'sd0, 17'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        configure_phase(ph);
      end
      if (ph == PHASES - 1) quiet_phase <= 1'b1;
      if (ph == 2 || ph == 3 || $urandom_range(0, 2) == 0) run_series(1'b1);
      while (sent_items < (ph + 1) * ITEMS_PER_PH) begin
        if ($urandom_range(0, 9) == 0)
          push_item($urandom_range(0, 1), IDX_W'($urandom()), pick_sample(), pick_lag());
        else
          run_series(1'b0);
      end
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending_size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mlwta_pkg.sv
sv/mlwta_ram.sv
sv/mlwta_front.sv
sv/mlwta_queue.sv
sv/mlwta_back.sv
sv/masked_lag_weighted_time_average.sv
verif/masked_lag_weighted_time_average_test.sv
